>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, ignored while reset is held
`define SVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check, also active while reset is held
`define SVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/svm_pkg.sv
package svm_pkg;

  localparam int NUM_REGS    = 8;
  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam int STORE_DEPTH = 2048;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_LIMIT  = 1024;
  localparam int DATA_W      = 32;
  localparam int ENTRY_W     = DATA_W + 1;
  localparam int PC_W        = 17;
  localparam int PLEN_W      = 16;
  localparam int OP_W        = 4;
  localparam int STAT_W      = 4;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_HALT    = 4'd0,
    OP_PUSH    = 4'd1,
    OP_POP     = 4'd2,
    OP_ADD     = 4'd3,
    OP_SET     = 4'd4,
    OP_LOAD    = 4'd5,
    OP_STORE   = 4'd6,
    OP_PRINT   = 4'd7,
    OP_CAT     = 4'd8,
    OP_PEEK    = 4'd9,
    OP_MOVEPOP = 4'd10,
    OP_REGPUSH = 4'd11,
    OP_MOVE    = 4'd12,
    OP_BRANCH  = 4'd13,
    OP_CMPBR   = 4'd14,
    OP_NOP     = 4'd15
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 4'd0,
    ST_HALT      = 4'd1,
    ST_UNDER     = 4'd2,
    ST_PEEKEMPTY = 4'd3,
    ST_OOB       = 4'd4,
    ST_UNINIT    = 4'd5,
    ST_POPEMPTY  = 4'd6,
    ST_BADBR     = 4'd7,
    ST_FULL      = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_POP,
    S_ADD1,
    S_ADD2,
    S_LOAD,
    S_STORE,
    S_PRINT,
    S_CAT,
    S_PEEK,
    S_RPUSH,
    S_MOVE,
    S_CB1,
    S_CB2,
    S_DONE
  } state_t;

endpackage

>>> design/svm_ram.sv
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/stack_vm_instruction_executor_core.sv
// channel  | dir | ports                   | beat contents
// ---------+-----+-------------------------+---------------------------------------
// cfg      | in  | cfg_wr_en, cfg_wr_data  | program_length
// in       | in  | in_tvalid/tready        | tuser: opcode; tdata: a, b, c
// out      | out | out_tvalid/tready       | tuser: status, print_valid;
//          |     |                         | tdata: print_value, next_pc
//
// Each instruction passes through accept, decode and issue, any read states on the
// single-read-port data store or register file, and hand-off.
// After reset a clearing pass zeroes the whole data store; in_tready stays low
// meanwhile, configuration writes are taken throughout.
// A stalled result holds in the output register; one further beat may be
// accepted and executed, and waits in the hand-off state.
module stack_vm_instruction_executor_core
  import svm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [PLEN_W-1:0]      cfg_wr_data,  // program_length
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // operand_a, operand_b, operand_c
  input  logic [OP_W-1:0]        in_tuser,     // opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,    // print_value, next_pc, zero pad
  output logic [OUT_TUSER_W-1:0] out_tuser     // status, print_valid
);

  state_t                state_r, state_nxt;
  logic [PC_W-1:0]       pc_r, pc_nxt;
  logic                  run_r, run_nxt;
  logic [CNT_W-1:0]      sc_r, sc_nxt;
  logic                  pop_held_r, pop_held_nxt;
  logic [DATA_W-1:0]     popped_r, popped_nxt;
  logic [DATA_W-1:0]     tmp_r, tmp_nxt;
  logic [NUM_REGS-1:0]   reg_vld_r, reg_vld_nxt;
  logic                  reg_rv_r, reg_rv_nxt;
  logic [PLEN_W-1:0]     prog_len_r, prog_len_nxt;
  logic [STORE_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  op_t                   op_r, op_nxt;
  logic [DATA_W-1:0]     a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  res_pvf_r, res_pvf_nxt;
  logic [DATA_W-1:0]     res_pval_r, res_pval_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic                  out_pvf_r, out_pvf_nxt;
  logic [DATA_W-1:0]     out_pval_r, out_pval_nxt;
  logic [PC_W-1:0]       out_pc_r, out_pc_nxt;

  logic                  st_we;
  logic [STORE_AW-1:0]   st_waddr, st_raddr;
  logic [ENTRY_W-1:0]    st_wdata, st_rdata;
  logic                  rf_we;
  logic [REG_AW-1:0]     rf_waddr, rf_raddr;
  logic [DATA_W-1:0]     rf_wdata, rf_rdata;

  logic                  fin;
  status_t               f_status;
  logic                  f_pv_en;
  logic [DATA_W-1:0]     f_pv;
  logic [DATA_W-1:0]     f_target;

  logic [CNT_W-1:0]      sc_m1, sc_m2;
  logic                  ok_a, ok_b, st_full, br_bad_a, br_bad_c;
  logic [DATA_W-1:0]     br_tgt_a, br_tgt_c, reg_data, st_data;
  logic                  st_vld;

  svm_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  svm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_regs (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  assign sc_m1    = sc_r - CNT_W'(1);
  assign sc_m2    = sc_r - CNT_W'(2);
  assign ok_a     = a_r < DATA_W'(NUM_REGS);
  assign ok_b     = b_r < DATA_W'(NUM_REGS);
  assign st_full  = sc_r == CNT_W'(STORE_DEPTH);
  assign br_tgt_a = DATA_W'(pc_r) + a_r;
  assign br_tgt_c = DATA_W'(pc_r) + c_r;
  assign br_bad_a = br_tgt_a > DATA_W'(prog_len_r);
  assign br_bad_c = br_tgt_c > DATA_W'(prog_len_r);
  assign reg_data = reg_rv_r ? rf_rdata : '0;
  assign st_data  = st_rdata[DATA_W-1:0];
  assign st_vld   = st_rdata[DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pc_r         <= '0;
      run_r        <= 1'b1;
      sc_r         <= '0;
      pop_held_r   <= 1'b0;
      reg_vld_r    <= '0;
      prog_len_r   <= '0;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      run_r        <= run_nxt;
      sc_r         <= sc_nxt;
      pop_held_r   <= pop_held_nxt;
      reg_vld_r    <= reg_vld_nxt;
      prog_len_r   <= prog_len_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r     <= popped_nxt;
    tmp_r        <= tmp_nxt;
    reg_rv_r     <= reg_rv_nxt;
    op_r         <= op_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    c_r          <= c_nxt;
    res_status_r <= res_status_nxt;
    res_pvf_r    <= res_pvf_nxt;
    res_pval_r   <= res_pval_nxt;
    out_status_r <= out_status_nxt;
    out_pvf_r    <= out_pvf_nxt;
    out_pval_r   <= out_pval_nxt;
    out_pc_r     <= out_pc_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    run_nxt        = run_r;
    sc_nxt         = sc_r;
    pop_held_nxt   = pop_held_r;
    popped_nxt     = popped_r;
    tmp_nxt        = tmp_r;
    reg_vld_nxt    = reg_vld_r;
    prog_len_nxt   = cfg_wr_en ? cfg_wr_data : prog_len_r;
    clr_cnt_nxt    = clr_cnt_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    c_nxt          = c_r;
    res_status_nxt = res_status_r;
    res_pvf_nxt    = res_pvf_r;
    res_pval_nxt   = res_pval_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pvf_nxt    = out_pvf_r;
    out_pval_nxt   = out_pval_r;
    out_pc_nxt     = out_pc_r;
    in_tready      = 1'b0;

    st_we    = 1'b0;
    st_waddr = sc_r[STORE_AW-1:0];
    st_wdata = '0;
    st_raddr = sc_m1[STORE_AW-1:0];
    rf_we    = 1'b0;
    rf_waddr = a_r[REG_AW-1:0];
    rf_wdata = reg_data;
    rf_raddr = a_r[REG_AW-1:0];

    fin      = 1'b0;
    f_status = ST_OK;
    f_pv_en  = 1'b0;
    f_pv     = '0;
    f_target = DATA_W'(pc_r);

    unique case (state_r)
      S_CLEAR: begin
        st_we       = 1'b1;
        st_waddr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + STORE_AW'(1);
        if (clr_cnt_r == STORE_AW'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = op_t'(in_tuser);
          a_nxt     = in_tdata[DATA_W-1:0];
          b_nxt     = in_tdata[2*DATA_W-1:DATA_W];
          c_nxt     = in_tdata[3*DATA_W-1:2*DATA_W];
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!run_r) begin
          fin      = 1'b1;
          f_status = ST_HALT;
        end else begin
          unique case (op_r)
            OP_HALT: begin
              fin      = 1'b1;
              f_status = ST_HALT;
            end
            OP_PUSH: begin
              fin = 1'b1;
              if (st_full) begin
                f_status = ST_FULL;
              end else begin
                st_we    = 1'b1;
                st_wdata = {1'b1, a_r};
                sc_nxt   = sc_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (sc_r == '0) begin
                fin      = 1'b1;
                f_status = ST_UNDER;
              end else begin
                state_nxt = S_POP;
              end
            end
            OP_ADD: begin
              if (sc_r < CNT_W'(2)) begin
                fin      = 1'b1;
                f_status = ST_UNDER;
              end else begin
                state_nxt = S_ADD1;
              end
            end
            OP_SET: begin
              fin = 1'b1;
              if (!ok_a) begin
                f_status = ST_OOB;
              end else begin
                rf_we    = 1'b1;
                rf_wdata = b_r;
              end
            end
            OP_LOAD: begin
              if (!ok_a || b_r > DATA_W'(ADDR_LIMIT)) begin
                fin      = 1'b1;
                f_status = ST_OOB;
              end else begin
                st_raddr  = b_r[STORE_AW-1:0];
                state_nxt = S_LOAD;
              end
            end
            OP_STORE: begin
              if (!ok_a || b_r > DATA_W'(ADDR_LIMIT)) begin
                fin      = 1'b1;
                f_status = ST_OOB;
              end else begin
                state_nxt = S_STORE;
              end
            end
            OP_PRINT: begin
              if (!ok_a) begin
                fin      = 1'b1;
                f_status = ST_OOB;
              end else begin
                state_nxt = S_PRINT;
              end
            end
            OP_CAT: begin
              if (a_r >= DATA_W'(STORE_DEPTH)) begin
                fin      = 1'b1;
                f_status = ST_OOB;
              end else begin
                st_raddr  = a_r[STORE_AW-1:0];
                state_nxt = S_CAT;
              end
            end
            OP_PEEK: begin
              if (sc_r == '0) begin
                fin      = 1'b1;
                f_status = ST_PEEKEMPTY;
              end else begin
                state_nxt = S_PEEK;
              end
            end
            OP_MOVEPOP: begin
              fin = 1'b1;
              if (!pop_held_r) begin
                f_status = ST_POPEMPTY;
              end else if (!ok_a) begin
                f_status = ST_OOB;
              end else begin
                rf_we        = 1'b1;
                rf_wdata     = popped_r;
                pop_held_nxt = 1'b0;
              end
            end
            OP_REGPUSH: begin
              if (!ok_a) begin
                fin      = 1'b1;
                f_status = ST_OOB;
              end else if (st_full) begin
                fin      = 1'b1;
                f_status = ST_FULL;
              end else begin
                state_nxt = S_RPUSH;
              end
            end
            OP_MOVE: begin
              if (!ok_a || !ok_b) begin
                fin      = 1'b1;
                f_status = ST_OOB;
              end else begin
                state_nxt = S_MOVE;
              end
            end
            OP_BRANCH: begin
              fin = 1'b1;
              if (br_bad_a) begin
                f_status = ST_BADBR;
              end else begin
                f_target = br_tgt_a;
              end
            end
            OP_CMPBR: begin
              if (!ok_a || !ok_b) begin
                fin      = 1'b1;
                f_status = ST_OOB;
              end else begin
                state_nxt = S_CB1;
              end
            end
            OP_NOP: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        fin          = 1'b1;
        popped_nxt   = st_data;
        pop_held_nxt = 1'b1;
        st_we        = 1'b1;
        st_waddr     = sc_m1[STORE_AW-1:0];
        sc_nxt       = sc_m1;
      end
      S_ADD1: begin
        tmp_nxt   = st_data;
        st_raddr  = sc_m2[STORE_AW-1:0];
        st_we     = 1'b1;
        st_waddr  = sc_m1[STORE_AW-1:0];
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        fin      = 1'b1;
        st_we    = 1'b1;
        st_waddr = sc_m2[STORE_AW-1:0];
        st_wdata = {1'b1, st_data + tmp_r};
        sc_nxt   = sc_m1;
      end
      S_LOAD: begin
        fin = 1'b1;
        if (!st_vld) begin
          f_status = ST_UNINIT;
        end else begin
          rf_we    = 1'b1;
          rf_wdata = st_data;
        end
      end
      S_STORE: begin
        fin      = 1'b1;
        st_we    = 1'b1;
        st_waddr = b_r[STORE_AW-1:0];
        st_wdata = {1'b1, reg_data};
      end
      S_PRINT: begin
        fin     = 1'b1;
        f_pv_en = 1'b1;
        f_pv    = reg_data;
      end
      S_CAT: begin
        fin      = 1'b1;
        f_pv_en  = 1'b1;
        f_pv     = st_data;
        st_we    = 1'b1;
        st_waddr = a_r[STORE_AW-1:0];
        st_wdata = {1'b1, st_data};
      end
      S_PEEK: begin
        fin     = 1'b1;
        f_pv_en = 1'b1;
        f_pv    = st_data;
      end
      S_RPUSH: begin
        fin      = 1'b1;
        st_we    = 1'b1;
        st_wdata = {1'b1, reg_data};
        sc_nxt   = sc_r + CNT_W'(1);
      end
      S_MOVE: begin
        fin      = 1'b1;
        rf_we    = 1'b1;
        rf_waddr = b_r[REG_AW-1:0];
      end
      S_CB1: begin
        tmp_nxt   = reg_data;
        rf_raddr  = b_r[REG_AW-1:0];
        state_nxt = S_CB2;
      end
      S_CB2: begin
        fin = 1'b1;
        if (reg_data == tmp_r) begin
          if (br_bad_c) begin
            f_status = ST_BADBR;
          end else begin
            f_target = br_tgt_c;
          end
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_pvf_nxt    = res_pvf_r;
          out_pval_nxt   = res_pval_r;
          out_pc_nxt     = pc_r;
          state_nxt      = S_IDLE;
        end
      end
    endcase

    if (fin) begin
      res_status_nxt = f_status;
      res_pvf_nxt    = f_pv_en && (f_status == ST_OK);
      res_pval_nxt   = (f_pv_en && (f_status == ST_OK)) ? f_pv : '0;
      if (run_r && (f_status == ST_OK || op_r == OP_HALT)) begin
        pc_nxt = f_target[PC_W-1:0] + PC_W'(1);
      end
      if (f_status != ST_OK) begin
        run_nxt = 1'b0;
      end
      state_nxt = S_DONE;
    end

    if (rf_we) begin
      reg_vld_nxt[rf_waddr] = 1'b1;
    end
    reg_rv_nxt = reg_vld_r[rf_raddr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_TDATA_W - DATA_W - PC_W)'(0), out_pc_r, out_pval_r};
  assign out_tuser  = {out_pvf_r, out_status_r};

endmodule

>>> design/svm_checker.sv
`include "assert_macros.svh"

module svm_checker
  import svm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  logic                   stopped_r;
  logic [PC_W-1:0]        last_pc_r;
  logic                   out_beat;
  logic                   out_stall;
  logic                   stopped_out;
  logic [STAT_W-1:0]      o_status;
  logic                   o_pvf;
  logic [DATA_W-1:0]      o_pval;
  logic [PC_W-1:0]        o_pc;
  logic                   print_ok;
  logic                   halt_only;
  logic [OUT_TUSER_W+OUT_TDATA_W-1:0] out_word;

  assign out_beat    = out_tvalid && out_tready;
  assign out_stall   = out_tvalid && !out_tready;
  assign stopped_out = out_tvalid && stopped_r;
  assign o_status    = out_tuser[STAT_W-1:0];
  assign o_pvf       = out_tuser[STAT_W];
  assign o_pval      = out_tdata[DATA_W-1:0];
  assign o_pc        = out_tdata[DATA_W+PC_W-1:DATA_W];
  assign print_ok    = (!o_pvf || o_status == ST_OK) && (o_pvf || o_pval == '0);
  assign halt_only   = (o_status == ST_HALT) && !o_pvf;
  assign out_word    = {out_tuser, out_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= 1'b0;
    end else if (out_beat && o_status != ST_OK) begin
      stopped_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      last_pc_r <= o_pc;
    end
  end

  `SVM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid right after reset")

  `SVM_ASSERT(a_out_hold, out_stall |=> (out_tvalid && $stable(out_word)), "stalled beat changed")

  `SVM_ASSERT(a_print_ok, out_tvalid |-> print_ok, "print data inconsistent with status")

  `SVM_ASSERT(a_stopped_halt, stopped_out |-> halt_only, "stopped machine not halted")

  `SVM_ASSERT(a_stopped_pc, stopped_out |-> (o_pc == last_pc_r), "counter moved after stop")

endmodule

bind stack_vm_instruction_executor_core svm_checker u_svm_checker (.*);

>>> verif/stack_vm_instruction_executor_core_tb.sv
`timescale 1ns / 1ps

module stack_vm_instruction_executor_core_tb
  import svm_pkg::*;
();

  typedef struct {
    status_t               status;
    logic                  print_valid;
    logic [DATA_W-1:0]     print_value;
    logic [PC_W-1:0]       next_pc;
  } vm_result_t;

  class vm_scoreboard;
    logic [PLEN_W-1:0] prog_len;
    logic [PC_W-1:0]   pc;
    bit                running;
    int unsigned       depth;
    logic [DATA_W-1:0] mem [STORE_DEPTH];
    bit                valid_bit [STORE_DEPTH];
    logic [DATA_W-1:0] regs [NUM_REGS];
    logic [DATA_W-1:0] pop_reg;
    bit                pop_held;
    vm_result_t        pending_results [$];
    int                errors;

    function new();
      prog_len = '0;
      pc = '0;
      running = 1;
      depth = 0;
      pop_reg = '0;
      pop_held = 0;
      errors = 0;
      foreach (mem[i]) begin
        mem[i] = '0;
        valid_bit[i] = 0;
      end
      foreach (regs[i]) regs[i] = '0;
    endfunction

    function bit reg_ok(logic [31:0] r);
      return r < NUM_REGS;
    endfunction

    function void push_top(logic [DATA_W-1:0] v);
      mem[depth] = v;
      valid_bit[depth] = 1;
      depth++;
    endfunction

    function logic [DATA_W-1:0] pop_top();
      logic [DATA_W-1:0] v;
      depth--;
      v = mem[depth];
      mem[depth] = '0;
      valid_bit[depth] = 0;
      return v;
    endfunction

    function bit branch_ok(logic [31:0] off, output logic [PC_W-1:0] tgt);
      logic [31:0] t;
      t = {15'b0, pc} + off;
      tgt = t[PC_W-1:0];
      return t <= {16'b0, prog_len};
    endfunction

    function void note_instruction(logic [OP_W-1:0] op, logic [31:0] a, b, c);
      vm_result_t r;
      logic [PC_W-1:0] tgt;
      logic [DATA_W-1:0] x, y;
      r.status = ST_OK;
      r.print_valid = 0;
      r.print_value = '0;
      tgt = pc;
      if (!running) begin
        r.status = ST_HALT;
      end else begin
        case (op)
          OP_HALT: begin
            running = 0;
            r.status = ST_HALT;
          end
          OP_PUSH: begin
            if (depth >= STORE_DEPTH) r.status = ST_FULL;
            else push_top(a);
          end
          OP_POP: begin
            if (depth == 0) r.status = ST_UNDER;
            else begin
              pop_reg = pop_top();
              pop_held = 1;
            end
          end
          OP_ADD: begin
            if (depth < 2) r.status = ST_UNDER;
            else begin
              x = pop_top();
              y = pop_top();
              push_top(y + x);
            end
          end
          OP_SET: begin
            if (!reg_ok(a)) r.status = ST_OOB;
            else regs[a[REG_AW-1:0]] = b;
          end
          OP_LOAD: begin
            if (!reg_ok(a) || b > 32'(ADDR_LIMIT)) r.status = ST_OOB;
            else if (!valid_bit[b[STORE_AW-1:0]]) r.status = ST_UNINIT;
            else regs[a[REG_AW-1:0]] = mem[b[STORE_AW-1:0]];
          end
          OP_STORE: begin
            if (!reg_ok(a) || b > 32'(ADDR_LIMIT)) r.status = ST_OOB;
            else begin
              mem[b[STORE_AW-1:0]] = regs[a[REG_AW-1:0]];
              valid_bit[b[STORE_AW-1:0]] = 1;
            end
          end
          OP_PRINT: begin
            if (!reg_ok(a)) r.status = ST_OOB;
            else begin
              r.print_valid = 1;
              r.print_value = regs[a[REG_AW-1:0]];
            end
          end
          OP_CAT: begin
            if (a >= 32'(STORE_DEPTH)) r.status = ST_OOB;
            else begin
              valid_bit[a[STORE_AW-1:0]] = 1;
              r.print_valid = 1;
              r.print_value = mem[a[STORE_AW-1:0]];
            end
          end
          OP_PEEK: begin
            if (depth == 0) r.status = ST_PEEKEMPTY;
            else begin
              r.print_valid = 1;
              r.print_value = mem[depth-1];
            end
          end
          OP_MOVEPOP: begin
            if (!pop_held) r.status = ST_POPEMPTY;
            else if (!reg_ok(a)) r.status = ST_OOB;
            else begin
              pop_held = 0;
              regs[a[REG_AW-1:0]] = pop_reg;
            end
          end
          OP_REGPUSH: begin
            if (!reg_ok(a)) r.status = ST_OOB;
            else if (depth >= STORE_DEPTH) r.status = ST_FULL;
            else push_top(regs[a[REG_AW-1:0]]);
          end
          OP_MOVE: begin
            if (!reg_ok(a) || !reg_ok(b)) r.status = ST_OOB;
            else regs[b[REG_AW-1:0]] = regs[a[REG_AW-1:0]];
          end
          OP_BRANCH: begin
            if (!branch_ok(a, tgt)) r.status = ST_BADBR;
          end
          OP_CMPBR: begin
            if (!reg_ok(a) || !reg_ok(b)) r.status = ST_OOB;
            else if (regs[a[REG_AW-1:0]] == regs[b[REG_AW-1:0]]) begin
              if (!branch_ok(c, tgt)) r.status = ST_BADBR;
            end
          end
          default: ;
        endcase
        if (r.status == ST_OK || op == OP_HALT) begin
          pc = tgt + 1'b1;
        end else begin
          running = 0;
          r.print_valid = 0;
          r.print_value = '0;
        end
      end
      r.next_pc = pc;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_TUSER_W-1:0] tuser, logic [OUT_TDATA_W-1:0] tdata);
      vm_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result beat with no instruction outstanding");
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (tuser[3:0] !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, tuser[3:0]);
        errors++;
      end
      if (tuser[4] !== exp.print_valid) begin
        $error("print_valid: expected %0d, got %0d", exp.print_valid, tuser[4]);
        errors++;
      end
      if (tdata[31:0] !== exp.print_value) begin
        $error("print_value: expected %h, got %h", exp.print_value, tdata[31:0]);
        errors++;
      end
      if (tdata[48:32] !== exp.next_pc) begin
        $error("next_pc: expected %0d, got %0d", exp.next_pc, tdata[48:32]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [PLEN_W-1:0]      cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // operand_a, operand_b, operand_c
  logic [OP_W-1:0]        in_tuser;   // opcode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // print_value, next_pc, zero pad
  logic [OUT_TUSER_W-1:0] out_tuser;  // status, print_valid

  vm_scoreboard sb = new();
  bit quiet = 0;

  stack_vm_instruction_executor_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_instruction(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  initial begin
    int hold;
    hold = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready = 0;
        hold--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready = 0;
        hold = $urandom_range(0, 11);
      end else begin
        out_tready = 1;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_instruction(op_t op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = op;
    in_tdata = {c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    in_tvalid = 0;
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_length(logic [PLEN_W-1:0] v);
    cfg_wr_en = 1;
    cfg_wr_data = v;
    sb.prog_len = v;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  // pick an instruction that keeps the machine running
  task automatic choose_instruction(output op_t op, output logic [31:0] a, b, c);
    int pick;
    int r;
    logic [31:0] tgt;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    r = $urandom_range(0, NUM_REGS-1);
    pick = $urandom_range(0, 99);
    if (pick < 14) op = OP_PUSH;
    else if (pick < 24) op = OP_POP;
    else if (pick < 32) op = OP_ADD;
    else if (pick < 38) op = OP_SET;
    else if (pick < 44) op = OP_LOAD;
    else if (pick < 50) op = OP_STORE;
    else if (pick < 55) op = OP_PRINT;
    else if (pick < 60) op = OP_CAT;
    else if (pick < 65) op = OP_PEEK;
    else if (pick < 70) op = OP_MOVEPOP;
    else if (pick < 76) op = OP_REGPUSH;
    else if (pick < 81) op = OP_MOVE;
    else if (pick < 87) op = OP_BRANCH;
    else if (pick < 95) op = OP_CMPBR;
    else op = OP_NOP;
    if ((op == OP_PUSH || op == OP_REGPUSH) && sb.depth > 48 && $urandom_range(0, 1))
      op = OP_POP;
    if ((op == OP_POP || op == OP_PEEK) && sb.depth == 0) op = OP_PUSH;
    if (op == OP_ADD && sb.depth < 2) op = OP_PUSH;
    if (op == OP_MOVEPOP && !sb.pop_held) op = OP_PRINT;
    if ((op == OP_PUSH || op == OP_REGPUSH) && sb.depth >= STORE_DEPTH) op = OP_NOP;
    case (op)
      OP_SET, OP_PRINT, OP_MOVEPOP, OP_REGPUSH: a = r;
      OP_STORE: begin
        a = r;
        b = $urandom_range(0, ADDR_LIMIT);
      end
      OP_LOAD: begin
        a = r;
        for (int t = 0; t < 8; t++) begin
          if (sb.depth > 0 && $urandom_range(0, 1))
            b = $urandom_range(0, (sb.depth > ADDR_LIMIT) ? ADDR_LIMIT : sb.depth - 1);
          else
            b = $urandom_range(0, ADDR_LIMIT);
          if (sb.valid_bit[b]) break;
        end
        if (!sb.valid_bit[b]) op = OP_STORE;
      end
      OP_CAT: a = $urandom_range(0, STORE_DEPTH-1);
      OP_MOVE: begin
        a = r;
        b = $urandom_range(0, NUM_REGS-1);
      end
      OP_BRANCH: begin
        tgt = $urandom_range(0, sb.prog_len);
        a = tgt - {15'b0, sb.pc};
      end
      OP_CMPBR: begin
        a = r;
        b = ($urandom_range(0, 2) == 0) ? r : $urandom_range(0, NUM_REGS-1);
        if (sb.regs[a] == sb.regs[b]) begin
          tgt = $urandom_range(0, sb.prog_len);
          c = tgt - {15'b0, sb.pc};
        end
      end
      default: ;
    endcase
  endtask

  // drive the machine into one halt or fault, chosen at random
  task automatic stop_machine();
    int kind;
    int sub;
    int start;
    bit found;
    logic [31:0] bad, addr, off, r;
    kind = $urandom_range(0, 7);
    r = $urandom_range(0, NUM_REGS-1);
    bad = $urandom;
    if (bad < NUM_REGS) bad = bad + NUM_REGS;
    case (kind)
      0: send_instruction(OP_HALT, $urandom, $urandom, $urandom);
      1, 2: begin
        while (sb.depth != 0) send_instruction(OP_POP, $urandom, $urandom, $urandom);
        if (kind == 2) begin
          send_instruction(OP_PEEK, $urandom, $urandom, $urandom);
        end else if ($urandom_range(0, 1)) begin
          send_instruction(OP_POP, $urandom, $urandom, $urandom);
        end else begin
          send_instruction(OP_PUSH, $urandom, $urandom, $urandom);
          send_instruction(OP_ADD, $urandom, $urandom, $urandom);
        end
      end
      3: begin
        sub = $urandom_range(0, 8);
        case (sub)
          0: send_instruction(OP_SET, bad, $urandom, $urandom);
          1: begin
            addr = $urandom;
            if (addr <= ADDR_LIMIT) addr = addr + ADDR_LIMIT + 1;
            send_instruction(OP_LOAD, r, addr, $urandom);
          end
          2: send_instruction(OP_STORE, bad, $urandom_range(0, ADDR_LIMIT), $urandom);
          3: send_instruction(OP_PRINT, bad, $urandom, $urandom);
          4: begin
            addr = $urandom;
            if (addr < STORE_DEPTH) addr = addr + STORE_DEPTH;
            send_instruction(OP_CAT, addr, $urandom, $urandom);
          end
          5: begin
            if (!sb.pop_held) begin
              if (sb.depth == 0) send_instruction(OP_PUSH, $urandom, $urandom, $urandom);
              send_instruction(OP_POP, $urandom, $urandom, $urandom);
            end
            send_instruction(OP_MOVEPOP, bad, $urandom, $urandom);
          end
          6: send_instruction(OP_REGPUSH, bad, $urandom, $urandom);
          7: send_instruction(OP_MOVE, r, bad, $urandom);
          default: send_instruction(OP_CMPBR, bad, r, $urandom);
        endcase
      end
      4: begin
        found = 0;
        addr = '0;
        start = $urandom_range(0, ADDR_LIMIT);
        for (int i = 0; i <= ADDR_LIMIT && !found; i++) begin
          if (!sb.valid_bit[(start + i) % (ADDR_LIMIT + 1)]) begin
            found = 1;
            addr = (start + i) % (ADDR_LIMIT + 1);
          end
        end
        if (found) send_instruction(OP_LOAD, r, addr, $urandom);
        else send_instruction(OP_HALT, $urandom, $urandom, $urandom);
      end
      5: begin
        if (sb.pop_held) send_instruction(OP_MOVEPOP, r, $urandom, $urandom);
        send_instruction(OP_MOVEPOP, $urandom, $urandom, $urandom);
      end
      6: begin
        off = $urandom;
        if ({15'b0, sb.pc} + off <= {16'b0, sb.prog_len})
          off = {16'b0, sb.prog_len} + 1 - {15'b0, sb.pc};
        if ($urandom_range(0, 1)) send_instruction(OP_BRANCH, off, $urandom, $urandom);
        else send_instruction(OP_CMPBR, r, r, off);
      end
      default: begin
        while (sb.depth < STORE_DEPTH) begin
          if ($urandom_range(0, 1))
            send_instruction(OP_PUSH, $urandom, $urandom, $urandom);
          else
            send_instruction(OP_REGPUSH, $urandom_range(0, NUM_REGS-1), $urandom, $urandom);
        end
        if ($urandom_range(0, 1)) send_instruction(OP_PUSH, $urandom, $urandom, $urandom);
        else send_instruction(OP_REGPUSH, r, $urandom, $urandom);
      end
    endcase
  endtask

  initial begin
    op_t op;
    logic [31:0] a, b, c;
    logic [PLEN_W-1:0] lengths [5];
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (3) @(negedge clk);
    rst_n = 1;
    write_length(16'hFFFF);

    send_instruction(OP_PUSH, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_instruction(OP_PUSH, 32'h1, 32'h0, 32'h0);
    send_instruction(OP_ADD, 32'h0, 32'h0, 32'h0);
    send_instruction(OP_PUSH, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_instruction(OP_PUSH, 32'h8000_0000, 32'h0, 32'h0);
    send_instruction(OP_ADD, 32'h0, 32'h0, 32'h0);
    send_instruction(OP_PEEK, 32'h0, 32'h0, 32'h0);
    send_instruction(OP_POP, 32'h0, 32'h0, 32'h0);
    send_instruction(OP_CAT, 32'd1, 32'h0, 32'h0);
    send_instruction(OP_LOAD, 32'd1, 32'd1, 32'h0);
    send_instruction(OP_MOVEPOP, 32'd7, 32'h0, 32'h0);
    send_instruction(OP_SET, 32'd0, 32'h8000_0000, 32'h0);
    send_instruction(OP_STORE, 32'd0, 32'(ADDR_LIMIT), 32'h0);
    send_instruction(OP_LOAD, 32'd6, 32'(ADDR_LIMIT), 32'h0);
    send_instruction(OP_PRINT, 32'd6, 32'h0, 32'h0);
    send_instruction(OP_CAT, 32'(STORE_DEPTH - 1), 32'h0, 32'h0);
    send_instruction(OP_STORE, 32'd1, 32'd0, 32'h0);
    send_instruction(OP_REGPUSH, 32'd7, 32'h0, 32'h0);
    send_instruction(OP_MOVE, 32'd7, 32'd3, 32'h0);
    send_instruction(OP_CMPBR, 32'd3, 32'd7, 32'd65535 - {15'b0, sb.pc});
    send_instruction(OP_PRINT, 32'd3, 32'h0, 32'h0);
    send_instruction(OP_BRANCH, 32'd0 - {15'b0, sb.pc}, 32'h0, 32'h0);
    send_instruction(OP_CMPBR, 32'd0, 32'd1, 32'hFFFF_FFFF);
    send_instruction(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instruction(OP_PUSH, 32'h0, 32'h0, 32'h0);

    lengths[0] = 16'h0000;
    lengths[1] = PLEN_W'($urandom_range(1, 255));
    lengths[2] = 16'hFFFF;
    lengths[3] = PLEN_W'($urandom_range(0, 65535));
    lengths[4] = PLEN_W'($urandom_range(1, 40));
    for (int ph = 0; ph < 5; ph++) begin
      wait_for_idle();
      write_length(lengths[ph]);
      for (int n = 0; n < 330; n++) begin
        if (ph == 4 && n >= 180) quiet = 1;
        if ($urandom_range(0, 199) == 0) wait_for_idle();
        choose_instruction(op, a, b, c);
        send_instruction(op, a, b, c);
      end
    end

    stop_machine();
    repeat (12) send_instruction(op_t'($urandom_range(0, 15)), $urandom, $urandom, $urandom);
    in_tvalid = 0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
